/* rtl/core/ima_adpcm_block_encoder_defines.svh */
// Assertion macros shared by the ADPCM block encoder RTL.
// Every macro expects clk_i and rst_ni to exist in the including module.
`ifndef IMA_ADPCM_BLOCK_ENCODER_DEFINES_SVH
`define IMA_ADPCM_BLOCK_ENCODER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define IMAENC_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define IMAENC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/imaenc_pkg.sv */
// Types, constants and helper functions for the ADPCM block encoder.
// Used by every module in rtl/core; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package imaenc_pkg;

  localparam int SAMPLES_PER_BLOCK = 2041;
  localparam bit TINY_BLOCK = (SAMPLES_PER_BLOCK <= 1);
  localparam int POS_W = (SAMPLES_PER_BLOCK > 2) ? $clog2(SAMPLES_PER_BLOCK) : 1;
  localparam logic [POS_W-1:0] LAST_POS =
      (SAMPLES_PER_BLOCK > 1) ? POS_W'(SAMPLES_PER_BLOCK - 1) : '0;

  localparam int STEP_W = 15;
  localparam int IDX_W = 7;
  localparam logic [IDX_W-1:0] IDX_MAX = 7'd88;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [STEP_W-1:0] STEP_TABLE [0:88] = '{
    15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
    15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
    15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
    15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
    15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
    15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
    15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
    15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
    15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635,
    15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623,
    15'd27086, 15'd29794, 15'd32767
  };

  typedef struct packed {
    logic [15:0] sample;
    logic        start_stream;
  } enc_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       block_end;
  } enc_out_t;

  // One queue record: a whole header or a single packed byte.
  typedef struct packed {
    logic             hdr;
    logic [15:0]      data;
    logic [IDX_W-1:0] idx;
    logic             last;
  } rec_t;

  // Step index adjustment from the magnitude bits of a code.
  function automatic logic signed [7:0] idx_adjust(input logic [2:0] mag);
    logic signed [7:0] adj;
    if (!mag[2]) begin
      adj = -8'sd1;
    end else begin
      adj = $signed({4'b0000, {1'b0, mag[1:0]} + 3'd1, 1'b0});
    end
    return adj;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/ima_adpcm_block_encoder.sv */
// Top level of the 4-bit mono IMA ADPCM block encoder.
// Instantiates imaenc_front, imaenc_queue and imaenc_back; uses imaenc_pkg.
//
//   channel  | handshake             | word
//   ---------+-----------------------+-------------------------------------
//   input    | push / full           | in_item_i  {sample, start_stream}
//   output   | pop / empty           | out_item_o {out_byte, block_end}
//
// A sample is quantized in the cycle it is taken, so one sample per cycle
// enters as long as the four-entry record queue has room. The back end sends
// one byte per cycle while pop is held and the queue is not empty; a header
// record yields four bytes. Reset clears the predictor, step index, position
// and queue. A stalled output only fills the queue; full rises when it is full.
`timescale 1ns / 1ps
`default_nettype none

module ima_adpcm_block_encoder (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push,
  output logic                      full,
  input  wire imaenc_pkg::enc_in_t  in_item_i,
  input  wire logic                 pop,
  output logic                      empty,
  output imaenc_pkg::enc_out_t      out_item_o
);

  imaenc_pkg::rec_t rec, head;
  logic rec_wr, q_rd;

  imaenc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (push && !full),
    .item_i   (in_item_i),
    .rec_o    (rec),
    .rec_wr_o (rec_wr)
  );

  imaenc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (rec_wr),
    .wdata_i (rec),
    .rd_i    (q_rd),
    .rdata_o (head),
    .empty_o (empty),
    .full_o  (full)
  );

  imaenc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (empty),
    .pop_i   (pop),
    .q_rd_o  (q_rd),
    .out_o   (out_item_o)
  );

endmodule

`default_nettype wire

/* rtl/core/imaenc_queue.sv */
// Short record queue between the quantizer front and the byte back end.
// Flip-flop storage; depends on imaenc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module imaenc_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              wr_i,
  input  wire imaenc_pkg::rec_t  wdata_i,
  input  wire logic              rd_i,
  output imaenc_pkg::rec_t       rdata_o,
  output logic                   empty_o,
  output logic                   full_o
);

`include "ima_adpcm_block_encoder_defines.svh"

  imaenc_pkg::rec_t mem_q [imaenc_pkg::Q_DEPTH];
  logic [imaenc_pkg::Q_PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [imaenc_pkg::Q_CNT_W-1:0] cnt_q, cnt_d;
  logic do_wr, do_rd;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == imaenc_pkg::Q_CNT_W'(imaenc_pkg::Q_DEPTH));
  assign rdata_o = mem_q[rptr_q];
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;

  always_comb begin
    wptr_d = do_wr ? wptr_q + 1'b1 : wptr_q;
    rptr_d = do_rd ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  `IMAENC_ASSERT(a_q_no_overflow, wr_i, !full_o, "record written into a full queue")
  `IMAENC_ASSERT(a_q_cnt_range, 1'b1,
      cnt_q <= imaenc_pkg::Q_CNT_W'(imaenc_pkg::Q_DEPTH), "queue count out of range")

endmodule

`default_nettype wire

/* rtl/core/imaenc_front.sv */
// Front end: takes samples, tracks block position, quantizes and packs nibbles.
// Writes header or byte records to the queue; depends on imaenc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module imaenc_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 accept_i,
  input  wire imaenc_pkg::enc_in_t  item_i,
  output imaenc_pkg::rec_t          rec_o,
  output logic                      rec_wr_o
);

`include "ima_adpcm_block_encoder_defines.svh"

  logic [15:0]                        pred_q, pred_d;
  logic [imaenc_pkg::IDX_W-1:0]       idx_q, idx_d;
  logic [imaenc_pkg::POS_W-1:0]       pos_q, pos_d;
  logic [3:0]                         pend_q, pend_d;
  logic                               par_q, par_d;

  logic [imaenc_pkg::IDX_W-1:0]       idx_eff;
  logic [imaenc_pkg::POS_W-1:0]       pos_eff;
  logic                               par_eff;
  logic [3:0]                         pend_eff;
  logic [16:0]                        diff, mag, st, delta;
  logic [3:0]                         code;
  logic signed [17:0]                 pred_sum;
  logic signed [7:0]                  idx_sum;
  logic                               last;

  always_comb begin
    idx_eff  = item_i.start_stream ? '0 : idx_q;
    pos_eff  = item_i.start_stream ? '0 : pos_q;
    par_eff  = item_i.start_stream ? 1'b0 : par_q;
    pend_eff = item_i.start_stream ? 4'h0 : pend_q;

    // Three compare-subtract steps against step, step/2 and step/4.
    diff  = {item_i.sample[15], item_i.sample} - {pred_q[15], pred_q};
    code  = {diff[16], 3'b000};
    mag   = diff[16] ? (~diff + 17'd1) : diff;
    st    = {2'b00, imaenc_pkg::STEP_TABLE[idx_eff]};
    delta = st >> 3;
    if (mag >= st) begin
      code[2] = 1'b1;
      mag     = mag - st;
      delta   = delta + st;
    end
    st = st >> 1;
    if (mag >= st) begin
      code[1] = 1'b1;
      mag     = mag - st;
      delta   = delta + st;
    end
    st = st >> 1;
    if (mag >= st) begin
      code[0] = 1'b1;
      delta   = delta + st;
    end

    pred_sum = code[3] ? $signed({pred_q[15], pred_q[15], pred_q} - {1'b0, delta})
                       : $signed({pred_q[15], pred_q[15], pred_q} + {1'b0, delta});
    idx_sum  = $signed({1'b0, idx_eff}) + imaenc_pkg::idx_adjust(code[2:0]);
    last     = (pos_eff == imaenc_pkg::LAST_POS);

    pred_d   = pred_q;
    idx_d    = idx_q;
    pos_d    = pos_q;
    par_d    = par_q;
    pend_d   = pend_q;
    rec_wr_o = 1'b0;
    rec_o    = '{hdr: 1'b0, data: 16'h0000, idx: idx_eff, last: 1'b0};

    if (accept_i) begin
      if (pos_eff == '0) begin
        rec_wr_o = 1'b1;
        rec_o    = '{hdr: 1'b1, data: item_i.sample, idx: idx_eff,
                     last: imaenc_pkg::TINY_BLOCK};
        pred_d   = item_i.sample;
        idx_d    = idx_eff;
        pos_d    = imaenc_pkg::TINY_BLOCK ? '0 : imaenc_pkg::POS_W'(1);
        par_d    = 1'b0;
        pend_d   = 4'h0;
      end else begin
        if (pred_sum > 18'sd32767) begin
          pred_d = 16'h7fff;
        end else if (pred_sum < -18'sd32768) begin
          pred_d = 16'h8000;
        end else begin
          pred_d = pred_sum[15:0];
        end
        if (idx_sum < 8'sd0) begin
          idx_d = '0;
        end else if (idx_sum > $signed({1'b0, imaenc_pkg::IDX_MAX})) begin
          idx_d = imaenc_pkg::IDX_MAX;
        end else begin
          idx_d = idx_sum[imaenc_pkg::IDX_W-1:0];
        end
        pos_d = last ? '0 : pos_eff + 1'b1;
        if (!par_eff) begin
          // A block ending on a low nibble is sent at once with a zero high nibble.
          if (last) begin
            rec_wr_o = 1'b1;
            rec_o    = '{hdr: 1'b0, data: {12'h000, code}, idx: idx_eff, last: 1'b1};
            pend_d   = 4'h0;
            par_d    = 1'b0;
          end else begin
            pend_d = code;
            par_d  = 1'b1;
          end
        end else begin
          rec_wr_o = 1'b1;
          rec_o    = '{hdr: 1'b0, data: {8'h00, code, pend_eff}, idx: idx_eff, last: last};
          pend_d   = 4'h0;
          par_d    = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pred_q <= '0;
      idx_q  <= '0;
      pos_q  <= '0;
      pend_q <= '0;
      par_q  <= 1'b0;
    end else begin
      pred_q <= pred_d;
      idx_q  <= idx_d;
      pos_q  <= pos_d;
      pend_q <= pend_d;
      par_q  <= par_d;
    end
  end

  `IMAENC_ASSERT(a_fr_idx_range, 1'b1, idx_q <= imaenc_pkg::IDX_MAX, "step index above 88")
  `IMAENC_ASSERT(a_fr_par_pos, par_q, pos_q != '0, "nibble held at block start")
  `IMAENC_ASSERT_NXT(a_fr_start_hdr, accept_i && item_i.start_stream,
      !par_q && pend_q == 4'h0, "start of stream left a nibble pending")

endmodule

`default_nettype wire

/* rtl/core/imaenc_back.sv */
// Back end: turns queue records into output bytes, four for a header.
// Depends on imaenc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module imaenc_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire imaenc_pkg::rec_t     head_i,
  input  wire logic                 empty_i,
  input  wire logic                 pop_i,
  output logic                      q_rd_o,
  output imaenc_pkg::enc_out_t      out_o
);

`include "ima_adpcm_block_encoder_defines.svh"

  logic [1:0] sub_q, sub_d;
  logic       take;

  assign take = pop_i && !empty_i;

  always_comb begin
    out_o = '{out_byte: head_i.data[7:0], block_end: head_i.last};
    if (head_i.hdr) begin
      unique case (sub_q)
        2'd0: out_o = '{out_byte: head_i.data[7:0], block_end: 1'b0};
        2'd1: out_o = '{out_byte: head_i.data[15:8], block_end: 1'b0};
        2'd2: out_o = '{out_byte: {1'b0, head_i.idx}, block_end: 1'b0};
        default: out_o = '{out_byte: 8'h00, block_end: head_i.last};
      endcase
    end

    // A header record leaves the queue only with its fourth byte.
    q_rd_o = take && (!head_i.hdr || sub_q == 2'd3);
    sub_d  = sub_q;
    if (take && head_i.hdr) begin
      sub_d = sub_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q <= '0;
    end else begin
      sub_q <= sub_d;
    end
  end

  `IMAENC_ASSERT(a_bk_sub_hdr, sub_q != 2'd0, !empty_i && head_i.hdr,
      "header byte counter running without a header at the head")

endmodule

`default_nettype wire
